// ----- hw/rtl/mtil_pkg.sv -----
// Shared constants, codes and types for the monotonic table inverse lookup.
`default_nettype none

package mtil_pkg;

  localparam int TABLE_DEPTH_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int INDEX_W     = 10;  // entry_index and last_index width
  localparam int SAMPLE_W    = 32;  // signed sample and query width
  localparam int IN_TDATA_W  = 80;  // 10 + 32 + 32 bits, padded to bytes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;

  // Item kinds carried in the slave-side tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MODE = 1'd1;

  // Out-of-range handling
  localparam logic MODE_CLAMP = 1'b0;
  localparam logic MODE_ERROR = 1'b1;

  localparam logic [INDEX_W-1:0] LAST_INDEX_RST = 10'd1023;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Largest power of two that does not exceed v (v >= 1)
  function automatic logic [INDEX_W-1:0] top_pow2(input logic [INDEX_W-1:0] v);
    logic [INDEX_W-1:0] p;
    p = '0;
    for (int i = 0; i < INDEX_W; i++) begin
      if (v[i]) begin
        p = INDEX_W'(1) << i;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mtil_ram.sv -----
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none

module mtil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] ra_addr,
  input  wire logic [ADDR_W-1:0] rb_addr,
  output logic      [WIDTH-1:0]  ra_data,
  output logic      [WIDTH-1:0]  rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mtil_div.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
`default_nettype none

module mtil_div #(
  parameter int N_W = 49,
  parameter int D_W = 33
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [N_W-1:0]      dividend,
  input  wire logic [D_W-1:0]      divisor,
  output mtil_pkg::div_status_t    status,
  output logic      [N_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dsr;
  logic [D_W:0]     trial;
  logic             fits;

  assign trial = {rem, quotient[N_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(N_W);
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        // shift one dividend bit in, subtract when the divisor fits
        rem      <= fits ? D_W'(trial - {1'b0, dsr}) : trial[D_W-1:0];
        quotient <= {quotient[N_W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

// ----- hw/rtl/monotonic_table_inverse_lookup.sv -----
// Top level: sample table, binary-search sequencer and interpolation.
`default_nettype none

//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: op; tdata: entry_index,
//            |     |                              |   entry_value, query_value
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: position; tuser: outside, error
//  cfg       | in  | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// A write beat stores its sample in the RAM on the accept edge.
// A query beat walks the search through the two RAM read ports: it fetches and checks the
// end entries, then reads and checks one pair per probe (about log2(L)+1 probes, fewer on
// an early hit), runs the serial divider unless the final pair is flat, and then forms and
// posts the result; a query outside the table skips straight to posting.
// The next beat is taken once the result sits in the output register, even while
// the sink stalls it; reset clears control state only, the table holds garbage until
// written. The cfg channel is always ready.

module monotonic_table_inverse_lookup #(
  parameter int TABLE_DEPTH   = mtil_pkg::TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = mtil_pkg::FRACTION_BITS_DEF,
  localparam int POS_W        = mtil_pkg::INDEX_W + FRACTION_BITS,
  localparam int OUT_TDATA_W  = ((POS_W + 7) / 8) * 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // slave side
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [9:0] entry_index, [41:10] entry_value, [73:42] query_value
  input  wire logic [mtil_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] op
  input  wire logic                                 s_axis_tuser,
  // master side
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [POS_W-1:0] position
  output logic      [OUT_TDATA_W-1:0]               m_axis_tdata,
  // [0] outside, [1] error
  output logic      [1:0]                           m_axis_tuser,
  // configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mtil_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [mtil_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW     = mtil_pkg::INDEX_W;
  localparam int SW     = mtil_pkg::SAMPLE_W;
  localparam int A_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int C_W    = IW + 1;            // probe index, room for c2 + step
  localparam int NUM_W  = SW + 1;            // differences of two samples
  localparam int DVD_W  = NUM_W + FRACTION_BITS;
  localparam int SUM_W  = DVD_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_ENDS, ST_CMP_ENDS, ST_RD_PAIR, ST_CMP_PAIR, ST_DIVIDE, ST_POS, ST_FIN
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  logic [IW-1:0] last_index;
  logic          range_mode;
  logic [IW-1:0] l_eff_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= mtil_pkg::LAST_INDEX_RST;
      range_mode <= mtil_pkg::MODE_CLAMP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtil_pkg::CFG_LAST_INDEX: last_index <= cfg_data[IW-1:0];
        mtil_pkg::CFG_RANGE_MODE: range_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective last index: at least 1, at most TABLE_DEPTH-1
  always_comb begin
    if (last_index == '0) begin
      l_eff_cfg = IW'(1);
    end else if (32'(last_index) > TABLE_DEPTH - 1) begin
      l_eff_cfg = IW'(TABLE_DEPTH - 1);
    end else begin
      l_eff_cfg = last_index;
    end
  end

  // ---------------------------------------------------------------- input beat
  logic                 s_acc;
  logic [IW-1:0]        in_entry_index;
  logic [SW-1:0]        in_entry_value;
  logic signed [SW-1:0] in_query_value;

  assign s_axis_tready  = (state == ST_IDLE);
  assign s_acc          = s_axis_tvalid && s_axis_tready;
  assign in_entry_index = s_axis_tdata[IW-1:0];
  assign in_entry_value = s_axis_tdata[IW+SW-1:IW];
  assign in_query_value = signed'(s_axis_tdata[IW+2*SW-1:IW+SW]);

  // ---------------------------------------------------------------- table RAM
  // Writes happen only in idle and reads only during a query, so the two never
  // touch the same entry in overlapping cycles; the state machine is the interlock.
  logic           ram_we;
  logic [A_W-1:0] ra_addr;
  logic [A_W-1:0] rb_addr;
  logic [SW-1:0]  ra_data;
  logic [SW-1:0]  rb_data;

  logic [C_W-1:0] c2;       // upper entry of the probed interval
  logic [IW-1:0]  step;
  logic [IW-1:0]  l_eff_q;

  assign ram_we = s_acc && (s_axis_tuser == mtil_pkg::OP_WRITE)
                  && (32'(in_entry_index) < TABLE_DEPTH);

  always_comb begin
    if (state == ST_RD_ENDS) begin
      ra_addr = '0;
      rb_addr = A_W'(l_eff_q);
    end else begin
      ra_addr = A_W'(c2 - C_W'(1));
      rb_addr = A_W'(c2);
    end
  end

  mtil_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (A_W'(in_entry_index)),
    .wdata   (in_entry_value),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // ---------------------------------------------------------------- search logic
  logic signed [SW-1:0] x_q;
  logic                 mode_q;
  logic                 inc_q;
  logic signed [SW-1:0] rd_lo;      // entry 0 or entry c2-1
  logic signed [SW-1:0] rd_hi;      // entry L or entry c2

  assign rd_lo = signed'(ra_data);
  assign rd_hi = signed'(rb_data);

  // End check, valid in ST_CMP_ENDS
  logic inc_now;
  logic in_range;
  logic clamp_low;

  assign inc_now   = rd_hi > rd_lo;
  assign in_range  = (x_q >= rd_lo && x_q <= rd_hi) || (x_q <= rd_lo && x_q >= rd_hi);
  assign clamp_low = (x_q < rd_lo && rd_hi > rd_lo) || (x_q > rd_lo && rd_hi < rd_lo);

  // Probe check, valid in ST_CMP_PAIR
  logic           hit;
  logic           go_down;
  logic [C_W-1:0] c2_try;
  logic [C_W-1:0] c2_next;
  logic           finish;

  assign hit     = inc_q ? !(rd_hi < x_q || rd_lo > x_q) : !(rd_hi > x_q || rd_lo < x_q);
  assign go_down = inc_q ? (rd_hi > x_q) : (rd_hi < x_q);
  assign finish  = hit || (step == '0);

  always_comb begin
    c2_try = go_down ? c2 - C_W'(step) : c2 + C_W'(step);
    // stay within 1..L
    if (c2_try > C_W'(l_eff_q)) begin
      c2_try = c2_try - C_W'(step);
    end
    c2_next = (c2_try == '0) ? C_W'(1) : c2_try;
  end

  // ---------------------------------------------------------------- fraction
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] den;
  logic        [NUM_W-1:0] num_abs;
  logic        [NUM_W-1:0] den_abs;
  logic                    div_start;
  mtil_pkg::div_status_t   div_st;
  logic        [DVD_W-1:0] div_q;

  assign num     = NUM_W'(x_q) - NUM_W'(rd_lo);
  assign den     = NUM_W'(rd_hi) - NUM_W'(rd_lo);
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_abs = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);

  assign div_start = (state == ST_CMP_PAIR) && finish && (rd_hi != rd_lo);

  mtil_div #(
    .N_W (DVD_W),
    .D_W (NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_abs, {FRACTION_BITS{1'b0}}}),
    .divisor  (den_abs),
    .status   (div_st),
    .quotient (div_q)
  );

  // Position: (c2-1) plus the signed fraction, saturated to 0..L
  logic                    neg_q;
  logic                    equal_q;
  logic        [DVD_W-1:0] frac_mag;
  logic signed [SUM_W-1:0] base_s;
  logic signed [SUM_W-1:0] top_s;
  logic signed [SUM_W-1:0] sum_s;
  logic        [POS_W-1:0] pos_sat;

  always_comb begin
    frac_mag = equal_q ? (DVD_W'(1) << (FRACTION_BITS - 1)) : div_q;
    base_s   = signed'(SUM_W'(c2 - C_W'(1)) << FRACTION_BITS);
    top_s    = signed'(SUM_W'(l_eff_q) << FRACTION_BITS);
    sum_s    = neg_q ? base_s - signed'(SUM_W'(frac_mag))
                     : base_s + signed'(SUM_W'(frac_mag));
    if (sum_s < 0) begin
      pos_sat = '0;
    end else if (sum_s > top_s) begin
      pos_sat = POS_W'(top_s);
    end else begin
      pos_sat = POS_W'(sum_s);
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic [POS_W-1:0] res_pos;
  logic             res_outside;
  logic             res_error;
  logic [POS_W-1:0] out_pos;
  logic             out_outside;
  logic             out_error;
  logic [IW-1:0]    p2_cfg;

  assign p2_cfg = mtil_pkg::top_pow2(l_eff_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drain the output register; the final state posts on its own
      if (m_axis_tvalid && m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc && (s_axis_tuser == mtil_pkg::OP_QUERY)) begin
            x_q     <= in_query_value;
            l_eff_q <= l_eff_cfg;
            mode_q  <= range_mode;
            c2      <= C_W'(p2_cfg);
            step    <= p2_cfg >> 1;
            state   <= ST_RD_ENDS;
          end
        end
        ST_RD_ENDS: begin
          state <= ST_CMP_ENDS;
        end
        ST_CMP_ENDS: begin
          inc_q <= inc_now;
          if (!in_range) begin
            // beyond the table: flag it, clamp or zero the position
            res_outside <= 1'b1;
            res_error   <= (mode_q == mtil_pkg::MODE_ERROR);
            if ((mode_q == mtil_pkg::MODE_ERROR) || clamp_low) begin
              res_pos <= '0;
            end else begin
              res_pos <= POS_W'(l_eff_q) << FRACTION_BITS;
            end
            state <= ST_FIN;
          end else begin
            res_outside <= 1'b0;
            res_error   <= 1'b0;
            state       <= ST_RD_PAIR;
          end
        end
        ST_RD_PAIR: begin
          state <= ST_CMP_PAIR;
        end
        ST_CMP_PAIR: begin
          if (finish) begin
            // c2 holds; interval [c2-1, c2] is final, a flat one always adds one half
            neg_q   <= (rd_hi != rd_lo) && (num[NUM_W-1] != den[NUM_W-1]);
            equal_q <= (rd_hi == rd_lo);
            state   <= (rd_hi == rd_lo) ? ST_POS : ST_DIVIDE;
          end else begin
            c2    <= c2_next;
            step  <= step >> 1;
            state <= ST_RD_PAIR;
          end
        end
        ST_DIVIDE: begin
          if (div_st.done) begin
            state <= ST_POS;
          end
        end
        ST_POS: begin
          res_pos <= pos_sat;
          state   <= ST_FIN;
        end
        ST_FIN: begin
          // post when the output register is free or drains this cycle
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_pos       <= res_pos;
            out_outside   <= res_outside;
            out_error     <= res_error;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_pos);
  assign m_axis_tuser = {out_error, out_outside};

  // ---------------------------------------------------------------- checks
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIVIDE))
    else $error("divider finished outside the divide state");

  a_probe_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP_PAIR) |-> (c2 >= C_W'(1) && c2 <= C_W'(l_eff_q)))
    else $error("search probe left 1..L");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_st.busy)
    else $error("divider busy while taking new beats");

  a_fin_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && m_axis_tvalid && !m_axis_tready) |=> (state == ST_FIN))
    else $error("result dropped while output register was full");

endmodule

`default_nettype wire
